// ===== src/tiwn_pkg.sv =====
// Package for the two-input weighted neuron: operation and register codes,
// control struct and the saturation helper. No dependencies.
`timescale 1ns / 1ps

package tiwn_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        OP_SUM = 3'd0,
        OP_MIN = 3'd1,
        OP_MAX = 3'd2,
        OP_MUL = 3'd3,
        OP_DIV = 3'd4,
        OP_THR = 3'd5,
        OP_GT  = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        REG_OP_MODE    = 3'd0,
        REG_WEIGHT_A   = 3'd1,
        REG_WEIGHT_B   = 3'd2,
        REG_OUT_WEIGHT = 3'd3,
        REG_FIRE_LEVEL = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               vld;
        op_t                mode;
        logic signed [31:0] x;
        logic signed [31:0] wbs;
        logic               flag;
        logic               qneg;
    } ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/two_input_weighted_neuron.sv =====
// Two-input weighted neuron: 5 front/back stages, 32+FRAC_BITS divider stages
// and an output register; throughput one item per cycle when not stalled.
// The whole pipeline halts while a result waits and m_tready is low.
// Synchronous active-low reset clears valid bits and sets registers to
// op_mode 0, weights 1.0, fire_level 0. Depends on tiwn_pkg and submodules.
`timescale 1ns / 1ps

module two_input_weighted_neuron #(
    parameter int FRAC_BITS = tiwn_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // in_a [31:0], in_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_value [31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = 32 + FRAC_BITS;

    logic [2:0]         op_mode_reg;
    logic signed [31:0] weight_a_reg, weight_b_reg, out_weight_reg, fire_level_reg;
    logic               adv, wr;
    tiwn_pkg::reg_idx_t idx;
    tiwn_pkg::ctl_t     f_ctl, d_ctl;
    logic [DW-1:0]      f_num, d_quo;
    logic [31:0]        f_den;
    logic signed [31:0] res_value;

    assign pready = 1'b1;
    assign idx    = tiwn_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg    <= 3'd0;
            weight_a_reg   <= 32'sd1 <<< FRAC_BITS;
            weight_b_reg   <= 32'sd1 <<< FRAC_BITS;
            out_weight_reg <= 32'sd1 <<< FRAC_BITS;
            fire_level_reg <= 32'sd0;
        end else if (wr) begin
            case (idx)
                tiwn_pkg::REG_OP_MODE:    op_mode_reg    <= pwdata[2:0];
                tiwn_pkg::REG_WEIGHT_A:   weight_a_reg   <= pwdata;
                tiwn_pkg::REG_WEIGHT_B:   weight_b_reg   <= pwdata;
                tiwn_pkg::REG_OUT_WEIGHT: out_weight_reg <= pwdata;
                tiwn_pkg::REG_FIRE_LEVEL: fire_level_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            tiwn_pkg::REG_OP_MODE:    prdata = {29'd0, op_mode_reg};
            tiwn_pkg::REG_WEIGHT_A:   prdata = weight_a_reg;
            tiwn_pkg::REG_WEIGHT_B:   prdata = weight_b_reg;
            tiwn_pkg::REG_OUT_WEIGHT: prdata = out_weight_reg;
            tiwn_pkg::REG_FIRE_LEVEL: prdata = fire_level_reg;
            default:                  prdata = 32'd0;
        endcase
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv & aresetn;
    assign m_tdata  = res_value;

    tiwn_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_vld     (s_tvalid),
        .in_a       (s_tdata[31:0]),
        .in_b       (s_tdata[63:32]),
        .op_mode    (op_mode_reg),
        .weight_a   (weight_a_reg),
        .weight_b   (weight_b_reg),
        .fire_level (fire_level_reg),
        .ctl_out    (f_ctl),
        .num_out    (f_num),
        .den_out    (f_den)
    );

    tiwn_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .ctl_in  (f_ctl),
        .num_in  (f_num),
        .den_in  (f_den),
        .ctl_out (d_ctl),
        .quo_out (d_quo)
    );

    tiwn_back #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .ctl_in     (d_ctl),
        .quo_in     (d_quo),
        .out_weight (out_weight_reg),
        .res_vld    (m_tvalid),
        .res_value  (res_value)
    );

endmodule

// ===== src/tiwn_front.sv =====
// Input register, weight multipliers and combine stage.
// Depends on tiwn_pkg.
`timescale 1ns / 1ps

module tiwn_front #(
    parameter int FRAC_BITS = tiwn_pkg::FRAC_BITS_DEF,
    parameter int DW        = 32 + FRAC_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_vld,
    input  logic signed [31:0]  in_a,
    input  logic signed [31:0]  in_b,
    input  logic [2:0]          op_mode,
    input  logic signed [31:0]  weight_a,
    input  logic signed [31:0]  weight_b,
    input  logic signed [31:0]  fire_level,
    output tiwn_pkg::ctl_t      ctl_out,
    output logic [DW-1:0]       num_out,
    output logic [31:0]         den_out
);

    logic               v0_reg, v1_reg;
    logic signed [31:0] a_reg, b_reg;
    logic signed [63:0] wa_reg, wb_reg;
    logic signed [63:0] pa, pb, sum;
    logic signed [31:0] satwa, satwb, satsum, satmin, satmax, dsig;
    logic [31:0]        wamag;
    tiwn_pkg::op_t      mode;
    tiwn_pkg::ctl_t     ctl_next, ctl_reg;
    logic [DW-1:0]      num_next, num_reg;
    logic [31:0]        den_next, den_reg;

    assign pa = 64'(weight_a) * 64'(a_reg);
    assign pb = 64'(weight_b) * 64'(b_reg);
    assign mode = tiwn_pkg::op_t'(op_mode);

    always_comb begin
        sum    = wa_reg + wb_reg;
        satwa  = tiwn_pkg::sat32(65'(wa_reg));
        satwb  = tiwn_pkg::sat32(65'(wb_reg));
        satsum = tiwn_pkg::sat32(65'(sum));
        satmin = (wa_reg < wb_reg) ? satwa : satwb;
        satmax = (wa_reg > wb_reg) ? satwa : satwb;
        dsig   = (satwb == 32'sd0) ? 32'sd1 : satwb;
        wamag  = satwa[31] ? 32'(-satwa) : 32'(satwa);
        num_next = DW'(wamag) << FRAC_BITS;
        den_next = dsig[31] ? 32'(-dsig) : 32'(dsig);
        ctl_next.vld  = v1_reg;
        ctl_next.mode = mode;
        ctl_next.wbs  = satwb;
        ctl_next.qneg = satwa[31] ^ dsig[31];
        ctl_next.flag = (mode == tiwn_pkg::OP_THR) ? (sum >= 64'(fire_level))
                                                    : (wa_reg > wb_reg);
        case (mode)
            tiwn_pkg::OP_SUM: ctl_next.x = satsum;
            tiwn_pkg::OP_MIN: ctl_next.x = satmin;
            tiwn_pkg::OP_MAX: ctl_next.x = satmax;
            tiwn_pkg::OP_MUL: ctl_next.x = satwa;
            default:          ctl_next.x = 32'sd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            ctl_reg.vld <= 1'b0;
        end else if (adv) begin
            v0_reg  <= in_vld;
            v1_reg  <= v0_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg   <= in_a;
            b_reg   <= in_b;
            wa_reg  <= pa >>> FRAC_BITS;
            wb_reg  <= pb >>> FRAC_BITS;
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;

endmodule

// ===== src/tiwn_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; carries control along.
// Depends on tiwn_pkg.
`timescale 1ns / 1ps

module tiwn_div #(
    parameter int FRAC_BITS = tiwn_pkg::FRAC_BITS_DEF,
    parameter int DW        = 32 + FRAC_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  tiwn_pkg::ctl_t ctl_in,
    input  logic [DW-1:0]  num_in,
    input  logic [31:0]    den_in,
    output tiwn_pkg::ctl_t ctl_out,
    output logic [DW-1:0]  quo_out
);

    tiwn_pkg::ctl_t ctl_reg [DW];
    logic [31:0]    rem_reg [DW];
    logic [DW-1:0]  dq_reg  [DW];
    logic [31:0]    den_reg [DW];

    genvar i;
    generate
        for (i = 0; i < DW; i++) begin : g_stage
            tiwn_pkg::ctl_t ctl_prev;
            logic [31:0]    rem_prev, den_prev;
            logic [DW-1:0]  dq_prev;
            logic [32:0]    sh, diff;
            logic           take;

            if (i == 0) begin : g_first
                assign ctl_prev = ctl_in;
                assign rem_prev = 32'd0;
                assign dq_prev  = num_in;
                assign den_prev = den_in;
            end else begin : g_rest
                assign ctl_prev = ctl_reg[i-1];
                assign rem_prev = rem_reg[i-1];
                assign dq_prev  = dq_reg[i-1];
                assign den_prev = den_reg[i-1];
            end

            assign sh   = {rem_prev, dq_prev[DW-1]};
            assign diff = sh - {1'b0, den_prev};
            assign take = (sh >= {1'b0, den_prev});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    ctl_reg[i].vld <= 1'b0;
                end else if (adv) begin
                    ctl_reg[i] <= ctl_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[i] <= take ? diff[31:0] : sh[31:0];
                    dq_reg[i]  <= {dq_prev[DW-2:0], take};
                    den_reg[i] <= den_prev;
                end
            end
        end
    endgenerate

    assign ctl_out = ctl_reg[DW-1];
    assign quo_out = dq_reg[DW-1];

endmodule

// ===== src/tiwn_back.sv =====
// Output scaling, second product stage and result select.
// Depends on tiwn_pkg.
`timescale 1ns / 1ps

module tiwn_back #(
    parameter int FRAC_BITS = tiwn_pkg::FRAC_BITS_DEF,
    parameter int DW        = 32 + FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  tiwn_pkg::ctl_t     ctl_in,
    input  logic [DW-1:0]      quo_in,
    input  logic signed [31:0] out_weight,
    output logic               res_vld,
    output logic signed [31:0] res_value
);

    logic signed [DW:0]   qs;
    logic signed [31:0]   xsel, t, r;
    logic signed [63:0]   p, p2;
    tiwn_pkg::ctl_t       c1_reg, c2_reg;
    logic signed [63:0]   p_reg, p2_reg;
    logic signed [31:0]   t_reg, res_reg;
    logic                 res_vld_reg;

    always_comb begin
        qs   = ctl_in.qneg ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in});
        xsel = (ctl_in.mode == tiwn_pkg::OP_DIV) ? tiwn_pkg::sat32(65'(qs)) : ctl_in.x;
        p    = 64'(out_weight) * 64'(xsel);
        t    = tiwn_pkg::sat32(65'(p_reg >>> FRAC_BITS));
        p2   = 64'(t) * 64'(c1_reg.wbs);
        case (c2_reg.mode)
            tiwn_pkg::OP_SUM,
            tiwn_pkg::OP_MIN,
            tiwn_pkg::OP_MAX,
            tiwn_pkg::OP_DIV: r = t_reg;
            tiwn_pkg::OP_MUL: r = tiwn_pkg::sat32(65'(p2_reg >>> FRAC_BITS));
            tiwn_pkg::OP_THR,
            tiwn_pkg::OP_GT:  r = c2_reg.flag ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            default:          r = 32'sd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg.vld  <= 1'b0;
            c2_reg.vld  <= 1'b0;
            res_vld_reg <= 1'b0;
        end else if (adv) begin
            c1_reg      <= ctl_in;
            c2_reg      <= c1_reg;
            res_vld_reg <= c2_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg   <= p;
            t_reg   <= t;
            p2_reg  <= p2;
            res_reg <= r;
        end
    end

    assign res_vld   = res_vld_reg;
    assign res_value = res_reg;

endmodule

// ===== dv/tb_two_input_weighted_neuron.sv =====
// Testbench for the two-input weighted neuron: drives items over the stream
// input, writes registers over APB, and checks each result against a predictor.
// Depends on tiwn_pkg and two_input_weighted_neuron.
`timescale 1ns / 1ps

module tb_two_input_weighted_neuron;

    localparam int F = tiwn_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = F + 38;
    localparam longint LIMIT = 2000000;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    two_input_weighted_neuron DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tiwn_pkg::op_t      mode_q;
    logic signed [31:0] wa_q, wb_q, ow_q, fire_q;
    logic [31:0]        expected_results[$];
    int                 mismatches = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 hold_cycles = 0;
    longint             cycles = 0;

    function automatic longint clamp32(longint v);
        return (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
    endfunction

    function automatic longint fix_floor(longint x);
        return x >>> F;
    endfunction

    function automatic longint fix_mul(longint x, longint y);
        return clamp32(fix_floor(x * y));
    endfunction

    function automatic logic [31:0] neuron_output(logic signed [31:0] a,
                                                  logic signed [31:0] b);
        longint wa, wb, r, d;
        wa = fix_floor(longint'(wa_q) * longint'(a));
        wb = fix_floor(longint'(wb_q) * longint'(b));
        case (mode_q)
            tiwn_pkg::OP_SUM: r = fix_mul(ow_q, clamp32(wa + wb));
            tiwn_pkg::OP_MIN: r = fix_mul(ow_q, clamp32(wa < wb ? wa : wb));
            tiwn_pkg::OP_MAX: r = fix_mul(ow_q, clamp32(wa > wb ? wa : wb));
            tiwn_pkg::OP_MUL: r = fix_mul(fix_mul(ow_q, clamp32(wa)), clamp32(wb));
            tiwn_pkg::OP_DIV: begin
                d = clamp32(wb);
                if (d == 0) d = 1;
                r = fix_mul(ow_q, clamp32((clamp32(wa) <<< F) / d));
            end
            tiwn_pkg::OP_THR: r = (wa + wb >= longint'(fire_q)) ? (64'sd1 <<< F) : 0;
            tiwn_pkg::OP_GT:  r = (wa > wb) ? (64'sd1 <<< F) : 0;
            default: r = 0;
        endcase
        return r[31:0];
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold when requested
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        logic [31:0] exp_v;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                exp_v = expected_results.pop_front();
                if (m_tdata !== exp_v) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_value mismatch: expected %h actual %h",
                                 exp_v, m_tdata);
                end
            end
        end
    end

    task automatic write_reg(tiwn_pkg::reg_idx_t idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx * 4); pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            tiwn_pkg::REG_OP_MODE:    mode_q = tiwn_pkg::op_t'(v[2:0]);
            tiwn_pkg::REG_WEIGHT_A:   wa_q = v;
            tiwn_pkg::REG_WEIGHT_B:   wb_q = v;
            tiwn_pkg::REG_OUT_WEIGHT: ow_q = v;
            default:                  fire_q = v;
        endcase
    endtask

    task automatic send_item(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(neuron_output(a, b));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(0, 4 << F)) - (32'd2 << F);
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed(16'($urandom))) << ($urandom_range(0, 8) + 8);
        endcase
    endfunction

    task automatic configure_random();
        write_reg(tiwn_pkg::REG_OP_MODE, $urandom_range(0, 7));
        write_reg(tiwn_pkg::REG_WEIGHT_A, $urandom_range(3) == 0 ? rand_value() : 32'd1 << F);
        write_reg(tiwn_pkg::REG_WEIGHT_B,
                  $urandom_range(3) == 0 ? rand_value() : rand_value() >>> 8);
        write_reg(tiwn_pkg::REG_OUT_WEIGHT, $urandom_range(1) ? 32'd1 << F : rand_value());
        write_reg(tiwn_pkg::REG_FIRE_LEVEL, rand_value());
    endtask

    task automatic test_directed();
        tiwn_pkg::op_t op;
        send_item(32'h0001_0000, 32'h0002_0000);
        drain();
        op = op.first();
        do begin
            write_reg(tiwn_pkg::REG_OP_MODE, op);
            send_item(32'h7fffffff, 32'h7fffffff);
            send_item(32'h80000000, 32'h80000000);
            send_item(32'h0003_0000, 32'h0000_0000);
            op = op.next();
            drain();
        end while (op != op.first());
        write_reg(tiwn_pkg::REG_OP_MODE, 32'd7);
        send_item(32'h1234_5678, 32'h8765_4321);
        drain();
        write_reg(tiwn_pkg::REG_OP_MODE, tiwn_pkg::OP_THR);
        write_reg(tiwn_pkg::REG_FIRE_LEVEL, 32'h0003_0000);
        send_item(32'h0001_0000, 32'h0002_0000);
        send_item(32'h0001_0000, 32'h0001_ffff);
        drain();
        write_reg(tiwn_pkg::REG_OP_MODE, tiwn_pkg::OP_GT);
        send_item(32'h0001_0000, 32'h0001_0000);
        drain();
        write_reg(tiwn_pkg::REG_WEIGHT_A, 32'h80000000);
        write_reg(tiwn_pkg::REG_WEIGHT_B, 32'h7fffffff);
        write_reg(tiwn_pkg::REG_OUT_WEIGHT, 32'h80000000);
        write_reg(tiwn_pkg::REG_OP_MODE, tiwn_pkg::OP_DIV);
        send_item(32'hffffffff, 32'h00000001);
        drain();
    endtask

    task automatic test_random(int items);
        for (int i = 0; i < items; i++) begin
            if (i % 60 == 0) begin
                drain();
                configure_random();
            end
            send_item(rand_value(), rand_value());
        end
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(tiwn_pkg::REG_OP_MODE, tiwn_pkg::OP_SUM);
        hold_cycles = 300;
        for (int i = 0; i < 150; i++) send_item(rand_value(), rand_value());
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
        for (int i = 0; i < 20; i++) send_item(rand_value(), rand_value());
        drain();
    endtask

    initial begin
        mode_q = tiwn_pkg::OP_SUM; wa_q = 32'd1 << F; wb_q = 32'd1 << F;
        ow_q = 32'd1 << F; fire_q = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        send_idle_pct = 23; recv_idle_pct = 71;
        test_random(550);
        send_idle_pct = 71; recv_idle_pct = 23;
        test_random(450);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        test_random(550);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/tiwn_pkg.sv
src/tiwn_front.sv
src/tiwn_div.sv
src/tiwn_back.sv
src/two_input_weighted_neuron.sv
dv/tb_two_input_weighted_neuron.sv
